FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is held off while reset is asserted.
`define ISU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ISU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/isu_pkg.sv
// ----------------------------------------------------------------------------
// isu_pkg
// Shared types and codes of the interval set selection update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isu_pkg;

    localparam logic [2:0] OP_REPLACE  = 3'd0;
    localparam logic [2:0] OP_ADD      = 3'd1;
    localparam logic [2:0] OP_SUBTRACT = 3'd2;
    localparam logic [2:0] OP_XOR      = 3'd3;
    localparam logic [2:0] OP_COMMIT   = 3'd4;

    localparam logic [1:0] PH_GAP   = 2'd0;
    localparam logic [1:0] PH_LEFT  = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;

    typedef struct packed {
        logic shift;
        logic load_all;
        logic load_tail;
    } isu_chain_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_FIN   = 5'b00100,
        ST_ALIGN = 5'b01000,
        ST_EMIT  = 5'b10000
    } isu_state_t;

endpackage

FILE: rtl/isu_cell.sv
// ----------------------------------------------------------------------------
// isu_cell
// One interval slot: holds a start and end, loads in parallel or shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isu_cell #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         shift_en,
    input  logic [W-1:0] shift_start,
    input  logic [W-1:0] shift_end,
    input  logic         load_en,
    input  logic [W-1:0] load_start,
    input  logic [W-1:0] load_end,
    output logic [W-1:0] start_q,
    output logic [W-1:0] end_q
);

    logic [W-1:0] start_reg;
    logic [W-1:0] end_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            start_reg <= load_start;
            end_reg   <= load_end;
        end
        else if (shift_en)
        begin
            start_reg <= shift_start;
            end_reg   <= shift_end;
        end
    end

    assign start_q = start_reg;
    assign end_q   = end_reg;

endmodule

FILE: rtl/isu_chain.sv
// ----------------------------------------------------------------------------
// isu_chain
// Row of interval cells; each cell takes its upper neighbor on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isu_chain #(
    parameter int N = 16,
    parameter int W = 32
) (
    input  logic                    clk,
    input  isu_pkg::isu_chain_ctrl_t ctrl,
    input  logic [W-1:0]            tail_in_start,
    input  logic [W-1:0]            tail_in_end,
    input  logic [W-1:0]            tail_ld_start,
    input  logic [W-1:0]            tail_ld_end,
    input  logic [W-1:0]            all_ld_start [N],
    input  logic [W-1:0]            all_ld_end   [N],
    output logic [W-1:0]            cell_start   [N],
    output logic [W-1:0]            cell_end     [N]
);

    import isu_pkg::*;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        logic [W-1:0] sh_s;
        logic [W-1:0] sh_e;
        logic [W-1:0] ld_s;
        logic [W-1:0] ld_e;
        logic         ld;

        if (k == N - 1)
        begin : g_tail
            assign sh_s = tail_in_start;
            assign sh_e = tail_in_end;
            assign ld   = ctrl.load_all | ctrl.load_tail;
            assign ld_s = ctrl.load_all ? all_ld_start[k] : tail_ld_start;
            assign ld_e = ctrl.load_all ? all_ld_end[k]   : tail_ld_end;
        end
        else
        begin : g_body
            assign sh_s = cell_start[k+1];
            assign sh_e = cell_end[k+1];
            assign ld   = ctrl.load_all;
            assign ld_s = all_ld_start[k];
            assign ld_e = all_ld_end[k];
        end

        isu_cell #(.W(W)) u_cell (
            .clk        (clk),
            .shift_en   (ctrl.shift),
            .shift_start(sh_s),
            .shift_end  (sh_e),
            .load_en    (ld),
            .load_start (ld_s),
            .load_end   (ld_e),
            .start_q    (cell_start[k]),
            .end_q      (cell_end[k])
        );
    end

endmodule

FILE: rtl/interval_set_selection_update.sv
// ----------------------------------------------------------------------------
// interval_set_selection_update
// Committed and shown interval tables updated by replace, union, difference,
// symmetric difference and commit requests.
// ----------------------------------------------------------------------------
// Usage:
// A request item enters on the s_ channel: tuser holds the operation, tdata
// the two positions. For add, subtract and xor the block then walks the
// committed chain, each entry in a gap, a left and a right phase, building
// the new shown set in the shown chain, and emits the shown intervals on
// the m_ channel with tlast on the final item.
// An empty shown set gives one item with region_valid low.
// After the last item the shown chain is rotated back to its start before
// the next request is taken.
// Replace, commit and unknown operations skip the walk.
// The block takes one request at a time; s_tready is high only when idle.
// A stalled receiver holds the output register and the emit sequence waits.
// Reset empties both tables and clears the output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module interval_set_selection_update #(
    parameter int MAX_REGIONS = 16,
    parameter int POS_BITS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // pos_a[31:0], pos_b[63:32]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // region_start[31:0], region_end[63:32]
    output logic [1:0]  m_tuser,   // region_valid[0], overflow[1]
    output logic        m_tlast
);

    import isu_pkg::*;

    localparam int N  = MAX_REGIONS;
    localparam int W  = POS_BITS;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [W-1:0] POS_MAX = {W{1'b1}};

    isu_state_t      state_reg, state_next;
    logic [2:0]      op_reg, op_next;
    logic [W-1:0]    a_reg, a_next;
    logic [W-1:0]    b_reg, b_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [1:0]      ph_reg, ph_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   ccount_reg, ccount_next;
    logic [CW-1:0]   scount_reg, scount_next;
    logic            ovf_reg, ovf_next;
    logic            placed_reg, placed_next;
    logic [W-1:0]    gs_reg, gs_next;
    logic            gopen_reg, gopen_next;
    logic            mv_reg, mv_next;
    logic [63:0]     md_reg, md_next;
    logic [1:0]      mu_reg, mu_next;
    logic            ml_reg, ml_next;

    isu_chain_ctrl_t c_ctrl, s_ctrl;
    logic [W-1:0]    c_s [N];
    logic [W-1:0]    c_e [N];
    logic [W-1:0]    s_s [N];
    logic [W-1:0]    s_e [N];
    logic [W-1:0]    s_tin_s, s_tin_e;
    logic [W-1:0]    s_tld_e;

    logic            pv, pu;
    logic [W-1:0]    ps, pe;
    logic [W-1:0]    in_a, in_b, lo, hi_gap;
    logic            active, disj, merge, slot_free;

    assign in_a = W'(s_tdata[31:0]);
    assign in_b = W'(s_tdata[63:32]);

    assign active    = (idx_reg < ccount_reg);
    assign disj      = (b_reg < c_s[0]) || (a_reg > c_e[0]);
    assign lo        = (gs_reg > a_reg) ? gs_reg : a_reg;
    assign hi_gap    = ((c_s[0] - W'(1)) < b_reg) ? (c_s[0] - W'(1)) : b_reg;
    assign slot_free = !mv_reg || m_tready;

    always_comb
    begin
        pv = 1'b0;
        pu = 1'b0;
        ps = a_reg;
        pe = b_reg;
        if (state_reg == ST_WALK && active)
        begin
            case (op_reg)
                OP_ADD:
                begin
                    if (ph_reg == PH_GAP && !placed_reg && c_s[0] > a_reg)
                    begin
                        pv = 1'b1;
                        pu = 1'b1;
                    end
                    else if (ph_reg == PH_LEFT)
                    begin
                        pv = 1'b1;
                        pu = 1'b1;
                        ps = c_s[0];
                        pe = c_e[0];
                    end
                end
                OP_SUBTRACT, OP_XOR:
                begin
                    if (ph_reg == PH_GAP)
                    begin
                        if (op_reg == OP_XOR && gopen_reg && gs_reg < c_s[0])
                        begin
                            pv = (lo <= hi_gap);
                            ps = lo;
                            pe = hi_gap;
                        end
                    end
                    else if (ph_reg == PH_LEFT)
                    begin
                        ps = c_s[0];
                        if (disj)
                        begin
                            pv = 1'b1;
                            pe = c_e[0];
                        end
                        else if (a_reg > c_s[0])
                        begin
                            pv = 1'b1;
                            pe = a_reg - W'(1);
                        end
                    end
                    else
                    begin
                        if (!disj && b_reg < c_e[0])
                        begin
                            pv = 1'b1;
                            ps = b_reg + W'(1);
                            pe = c_e[0];
                        end
                    end
                end
                default:
                begin
                    pv = 1'b0;
                end
            endcase
        end
        else if (state_reg == ST_FIN)
        begin
            case (op_reg)
                OP_REPLACE:
                begin
                    pv = 1'b1;
                end
                OP_ADD:
                begin
                    pv = !placed_reg;
                    pu = 1'b1;
                end
                OP_XOR:
                begin
                    pv = gopen_reg && (lo <= b_reg);
                    ps = lo;
                end
                default:
                begin
                    pv = 1'b0;
                end
            endcase
        end
    end

    assign merge = pu && (n_reg != '0) && (s_e[N-1] >= ps);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        idx_next    = idx_reg;
        ph_next     = ph_reg;
        n_next      = n_reg;
        ccount_next = ccount_reg;
        scount_next = scount_reg;
        ovf_next    = ovf_reg;
        placed_next = placed_reg;
        gs_next     = gs_reg;
        gopen_next  = gopen_reg;
        mv_next     = mv_reg && !m_tready;
        md_next     = md_reg;
        mu_next     = mu_reg;
        ml_next     = ml_reg;
        c_ctrl      = '0;
        s_ctrl      = '0;
        s_tin_s     = '0;
        s_tin_e     = '0;
        s_tld_e     = pe;

        if (pv)
        begin
            if (merge)
            begin
                s_ctrl.load_tail = (pe > s_e[N-1]);
            end
            else if (n_reg < CW'(N))
            begin
                s_ctrl.shift = 1'b1;
                s_tin_s      = ps;
                s_tin_e      = pe;
                n_next       = n_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tuser;
                    a_next      = (in_a > in_b) ? in_b : in_a;
                    b_next      = (in_a > in_b) ? in_a : in_b;
                    idx_next    = '0;
                    ph_next     = PH_GAP;
                    n_next      = '0;
                    ovf_next    = 1'b0;
                    placed_next = 1'b0;
                    gs_next     = '0;
                    gopen_next  = 1'b1;
                    case (s_tuser)
                        OP_REPLACE:
                        begin
                            state_next = ST_FIN;
                        end
                        OP_ADD, OP_SUBTRACT, OP_XOR:
                        begin
                            state_next = ST_WALK;
                        end
                        OP_COMMIT:
                        begin
                            c_ctrl.load_all = 1'b1;
                            ccount_next     = scount_reg;
                            state_next      = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (op_reg == OP_ADD && ph_reg == PH_GAP && pv)
                begin
                    placed_next = 1'b1;
                end
                if (ph_reg == PH_RIGHT)
                begin
                    c_ctrl.shift = 1'b1;
                    ph_next      = PH_GAP;
                    idx_next     = idx_reg + CW'(1);
                    if (active)
                    begin
                        if (c_e[0] == POS_MAX)
                        begin
                            gopen_next = 1'b0;
                        end
                        else
                        begin
                            gs_next = c_e[0] + W'(1);
                        end
                    end
                    if (idx_reg == CW'(N - 1))
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    ph_next = ph_reg + 2'd1;
                end
            end
            ST_FIN:
            begin
                idx_next   = n_next;
                state_next = ST_ALIGN;
            end
            ST_ALIGN:
            begin
                if (idx_reg == CW'(N))
                begin
                    scount_next = n_reg;
                    idx_next    = '0;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    s_ctrl.shift = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                end
            end
            ST_EMIT:
            begin
                s_tin_s = s_s[0];
                s_tin_e = s_e[0];
                if (scount_reg == '0)
                begin
                    if (slot_free)
                    begin
                        mv_next    = 1'b1;
                        md_next    = '0;
                        mu_next    = {ovf_reg, 1'b0};
                        ml_next    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_reg < scount_reg)
                begin
                    if (slot_free)
                    begin
                        mv_next      = 1'b1;
                        md_next      = {32'(s_e[0]), 32'(s_s[0])};
                        mu_next      = {ovf_reg, 1'b1};
                        ml_next      = (idx_reg + CW'(1) == scount_reg);
                        s_ctrl.shift = 1'b1;
                        idx_next     = idx_reg + CW'(1);
                        if (idx_reg == CW'(N - 1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    s_ctrl.shift = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                    if (idx_reg == CW'(N - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ccount_reg <= '0;
            scount_reg <= '0;
            mv_reg     <= 1'b0;
            idx_reg    <= '0;
            ph_reg     <= PH_GAP;
            n_reg      <= '0;
            ovf_reg    <= 1'b0;
            placed_reg <= 1'b0;
            gopen_reg  <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            ccount_reg <= ccount_next;
            scount_reg <= scount_next;
            mv_reg     <= mv_next;
            idx_reg    <= idx_next;
            ph_reg     <= ph_next;
            n_reg      <= n_next;
            ovf_reg    <= ovf_next;
            placed_reg <= placed_next;
            gopen_reg  <= gopen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        a_reg  <= a_next;
        b_reg  <= b_next;
        gs_reg <= gs_next;
        md_reg <= md_next;
        mu_reg <= mu_next;
        ml_reg <= ml_next;
    end

    isu_chain #(.N(N), .W(W)) u_committed (
        .clk          (clk),
        .ctrl         (c_ctrl),
        .tail_in_start(c_s[0]),
        .tail_in_end  (c_e[0]),
        .tail_ld_start(c_s[N-1]),
        .tail_ld_end  (c_e[N-1]),
        .all_ld_start (s_s),
        .all_ld_end   (s_e),
        .cell_start   (c_s),
        .cell_end     (c_e)
    );

    isu_chain #(.N(N), .W(W)) u_shown (
        .clk          (clk),
        .ctrl         (s_ctrl),
        .tail_in_start(s_tin_s),
        .tail_in_end  (s_tin_e),
        .tail_ld_start(s_s[N-1]),
        .tail_ld_end  (s_tld_e),
        .all_ld_start (c_s),
        .all_ld_end   (c_e),
        .cell_start   (s_s),
        .cell_end     (s_e)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

    `ISU_ASSERT(a_shown_count_range, scount_reg <= CW'(N), "shown count exceeds table size")
    `ISU_ASSERT(a_committed_count_range, ccount_reg <= CW'(N), "committed count exceeds table size")
    `ISU_ASSERT(a_accept_leaves_idle, (s_tvalid && s_tready) |=> (state_reg != ST_IDLE),
        "request accepted but sequencer stayed idle")

endmodule

FILE: tb/tb_interval_checker.sv
// ----------------------------------------------------------------------------
// tb_interval_checker
// Watches the request and region channels, predicts the shown interval set
// for every accepted request, and compares each emitted region field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_interval_checker
    import isu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_regions,
    output int          region_count,
    output int          overflow_count
);

    localparam int MAX_REGIONS = 16;

    typedef struct packed {
        logic [31:0] start_pos;
        logic [31:0] end_pos;
        logic        present;
        logic        ovf;
        logic        last_flag;
    } region_t;

    region_t     expected_regions[$];
    logic [31:0] comm_s[MAX_REGIONS];
    logic [31:0] comm_e[MAX_REGIONS];
    int          comm_n;
    logic [31:0] show_s[MAX_REGIONS];
    logic [31:0] show_e[MAX_REGIONS];
    int          show_n;
    logic [31:0] new_s[MAX_REGIONS];
    logic [31:0] new_e[MAX_REGIONS];
    int          new_n;
    logic        new_ovf;

    assign pending_regions = expected_regions.size();

    function automatic void add_piece(logic [31:0] s, logic [31:0] e);
        if (new_n < MAX_REGIONS)
        begin
            new_s[new_n] = s;
            new_e[new_n] = e;
            new_n++;
        end
        else
        begin
            new_ovf = 1'b1;
        end
    endfunction

    function automatic void merge_piece(logic [31:0] s, logic [31:0] e);
        if (new_n > 0 && new_e[new_n - 1] >= s)
        begin
            if (e > new_e[new_n - 1])
                new_e[new_n - 1] = e;
        end
        else
        begin
            add_piece(s, e);
        end
    endfunction

    function automatic void outside_piece(logic [31:0] s, logic [31:0] e,
                                          logic [31:0] a, logic [31:0] b);
        if (b < s || a > e)
        begin
            add_piece(s, e);
        end
        else
        begin
            if (a > s)
                add_piece(s, a - 1);
            if (b < e)
                add_piece(b + 1, e);
        end
    endfunction

    function automatic void inside_piece(logic [31:0] gs, logic [31:0] ge,
                                         logic [31:0] a, logic [31:0] b);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = (gs > a) ? gs : a;
        hi = (ge < b) ? ge : b;
        if (lo <= hi)
            add_piece(lo, hi);
    endfunction

    function automatic void predict_selection(logic [2:0] op, logic [31:0] pa,
                                              logic [31:0] pb);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] gs;
        logic        gap_open;
        logic        placed;
        logic        ovf;
        region_t     r;
        a = (pa > pb) ? pb : pa;
        b = (pa > pb) ? pa : pb;
        new_n = 0;
        new_ovf = 1'b0;
        ovf = 1'b0;
        placed = 1'b0;
        gs = '0;
        gap_open = 1'b1;
        case (op)
            OP_REPLACE: add_piece(a, b);
            OP_ADD:
            begin
                for (int i = 0; i < comm_n; i++)
                begin
                    if (!placed && comm_s[i] > a)
                    begin
                        merge_piece(a, b);
                        placed = 1'b1;
                    end
                    merge_piece(comm_s[i], comm_e[i]);
                end
                if (!placed)
                    merge_piece(a, b);
            end
            OP_SUBTRACT:
            begin
                for (int i = 0; i < comm_n; i++)
                    outside_piece(comm_s[i], comm_e[i], a, b);
            end
            OP_XOR:
            begin
                for (int i = 0; i < comm_n; i++)
                begin
                    if (gap_open && gs < comm_s[i])
                        inside_piece(gs, comm_s[i] - 1, a, b);
                    outside_piece(comm_s[i], comm_e[i], a, b);
                    if (comm_e[i] == 32'hFFFF_FFFF)
                        gap_open = 1'b0;
                    else
                        gs = comm_e[i] + 1;
                end
                if (gap_open)
                    inside_piece(gs, 32'hFFFF_FFFF, a, b);
            end
            OP_COMMIT:
            begin
                comm_s = show_s;
                comm_e = show_e;
                comm_n = show_n;
            end
            default: ;
        endcase
        if (op <= OP_XOR)
        begin
            show_s = new_s;
            show_e = new_e;
            show_n = new_n;
            ovf = new_ovf;
        end
        if (ovf)
            overflow_count++;
        if (show_n == 0)
        begin
            r = '{start_pos: '0, end_pos: '0, present: 1'b0, ovf: ovf, last_flag: 1'b1};
            expected_regions.push_back(r);
        end
        for (int i = 0; i < show_n; i++)
        begin
            r = '{start_pos: show_s[i], end_pos: show_e[i], present: 1'b1, ovf: ovf,
                  last_flag: (i == show_n - 1)};
            expected_regions.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        region_t r;
        if (!rst_n)
        begin
            comm_n = 0;
            show_n = 0;
            expected_regions.delete();
            fail_count <= 0;
            region_count <= 0;
            overflow_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                region_count <= region_count + 1;
                if (expected_regions.size() == 0)
                begin
                    $error("unexpected region item: tdata %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    r = expected_regions.pop_front();
                    if (m_tdata[31:0] !== r.start_pos || m_tdata[63:32] !== r.end_pos
                        || m_tuser[0] !== r.present || m_tuser[1] !== r.ovf
                        || m_tlast !== r.last_flag)
                    begin
                        if (m_tdata[31:0] !== r.start_pos)
                            $error("region_start: expected %h, got %h", r.start_pos,
                                   m_tdata[31:0]);
                        if (m_tdata[63:32] !== r.end_pos)
                            $error("region_end: expected %h, got %h", r.end_pos,
                                   m_tdata[63:32]);
                        if (m_tuser[0] !== r.present)
                            $error("region_valid: expected %b, got %b", r.present,
                                   m_tuser[0]);
                        if (m_tuser[1] !== r.ovf)
                            $error("overflow: expected %b, got %b", r.ovf, m_tuser[1]);
                        if (m_tlast !== r.last_flag)
                            $error("last: expected %b, got %b", r.last_flag, m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_selection(s_tuser, s_tdata[31:0], s_tdata[63:32]);
        end
    end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random selection requests into the interval set block
// under several idle and stall patterns and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import isu_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_CYCLES = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending_regions;
    int          region_count;
    int          overflow_count;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          request_count = 0;
    int          cycle_count = 0;
    logic [31:0] base_pos;

    always #4 clk = ~clk;

    interval_set_selection_update u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tb_interval_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending_regions (pending_regions),
        .region_count    (region_count),
        .overflow_count  (overflow_count)
    );

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] op, logic [31:0] pa, logic [31:0] pb);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pb, pa};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        s_tvalid <= 1'b0;
        request_count++;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return base_pos + $urandom_range(300);
        endcase
    endfunction

    task automatic send_random();
        logic [2:0] op;
        op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                       : 3'($urandom_range(4));
        send_request(op, pick_pos(), pick_pos());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_XOR, 32'h10, 32'h5);
        send_request(OP_SUBTRACT, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_ADD, 32'h20, 32'h30);
        send_request(OP_COMMIT, 32'h0, 32'h0);
        send_request(OP_ADD, 32'h31, 32'h40);
        send_request(OP_ADD, 32'h25, 32'h50);
        send_request(OP_COMMIT, 32'h0, 32'h0);
        send_request(OP_XOR, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_XOR, 32'h10, 32'h40);
        send_request(OP_SUBTRACT, 32'h28, 32'h2A);
        send_request(OP_REPLACE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_COMMIT, 32'h0, 32'h0);
        send_request(OP_XOR, 32'h0, 32'h0);
        send_request(3'd5, 32'h1, 32'h2);
        send_request(3'd7, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(OP_REPLACE, 32'h0, 32'h0);
        send_request(OP_COMMIT, 32'h0, 32'h0);
        for (int i = 1; i < 20; i++)
        begin
            send_request(OP_ADD, 32'(4 * i), 32'(4 * i + 1));
            send_request(OP_COMMIT, 32'h0, 32'h0);
        end
        send_request(OP_XOR, 32'h0, 32'hFF);
        send_request(OP_SUBTRACT, 32'h2, 32'h2);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            for (int n = 0; n < 85; n++)
            begin
                if (n % 30 == 0)
                begin
                    base_pos = ($urandom_range(3) == 0) ? 32'hFFFF_FE00 : $urandom;
                    send_request(OP_REPLACE, base_pos, base_pos + 10);
                    send_request(OP_COMMIT, 32'h0, 32'h0);
                end
                if (n == 50)
                begin
                    while (pending_regions != 0)
                        @(posedge clk);
                end
                send_random();
            end
        end

        while (pending_regions != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests and checked %0d region items.", request_count,
                 region_count);
        $display("Requests with table overflow: %0d.", overflow_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
